FILE: hw/rtl/scc_pkg.sv
// Shared types, widths and register codes of the shunt coulomb counter.
package scc_pkg;

  localparam int DATA_W        = 32;
  localparam int SAMPLE_W      = 12;
  localparam int OFFSET_W      = 13;
  localparam int GAIN_W        = 31;
  localparam int CNT_W         = 10;
  localparam int ADDR_W        = 4;
  localparam int FRAC_BITS_DEF = 5;
  localparam int WINDOW_DEF    = 1000;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(32);

  // Register indexes (byte address divided by four)
  localparam logic [1:0] REG_SINGLE = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_GAIN   = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0]      pos_sample;
    logic [SAMPLE_W-1:0]      neg_sample;
    logic signed [DATA_W-1:0] bus_voltage;
    logic                     hold;
  } scc_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] measured_current;
    logic [DATA_W-1:0]        idle_count;
    logic                     window_done;
    logic signed [DATA_W-1:0] average_current;
    logic signed [DATA_W-1:0] window_power;
    logic [DATA_W-1:0]        charge_in;
    logic [DATA_W-1:0]        charge_out;
  } scc_out_t;

endpackage

FILE: hw/rtl/scc_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module scc_div #(
  parameter int DVD_W = 32,
  parameter int DSR_W = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DSR_W-1:0]  rem_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DSR_W-1:0]  dsr_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  logic [DSR_W:0]    trial;
  logic              fits;
  logic [DSR_W:0]    diff;

  // Shift the next dividend bit into the remainder and try the subtract
  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  // Control: load on start, count the steps, pulse done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hw/rtl/scc_mul.sv
// Bit-serial shift-add multiplier for unsigned operands.
module scc_mul #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           done,
  output logic [2*W-1:0] product
);

  localparam int STEP_W = $clog2(W + 1);

  logic [W-1:0]      a_r;
  logic [W-1:0]      hi_r;
  logic [W-1:0]      lo_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [W:0]        sum;

  // Add the multiplicand when the current multiplier bit is set
  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift the partial product right one bit per step
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      hi_r <= sum[W:1];
      lo_r <= {sum[0], lo_r[W-1:1]};
    end
  end

  assign done    = done_r;
  assign product = {hi_r, lo_r};

endmodule

FILE: hw/rtl/shunt_coulomb_counter.sv
// Shunt coulomb counter top level: config registers, sequencer, sums and totals.
// Sequence: an accepted sample is divided bit-serially by the gain (S_DIV), then sorted
//   and summed (S_ACC) before its result goes to the output register (S_OUT).
// A sample that closes a window adds three more serial divides by the window
//   length and one serial 32-bit multiply.
// A new sample is taken only in S_IDLE, after the last result is loaded; a held sample is dropped.
// Reset (synchronous, rst_n low) clears sums, totals and counters, restores register defaults.
module shunt_coulomb_counter #(
  parameter int FRAC_BITS      = scc_pkg::FRAC_BITS_DEF,
  parameter int WINDOW_SAMPLES = scc_pkg::WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Sample requests
  input  logic                        in_valid,
  output logic                        in_ready,
  input  scc_pkg::scc_in_t            in_data,
  // Result requests
  output logic                        out_valid,
  input  logic                        out_ready,
  output scc_pkg::scc_out_t           out_data,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scc_pkg::ADDR_W-1:0]  paddr,
  input  logic [scc_pkg::DATA_W-1:0]  pwdata,
  output logic [scc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int DW    = scc_pkg::DATA_W;
  localparam int GW    = scc_pkg::GAIN_W;
  localparam int CW    = scc_pkg::CNT_W;
  localparam int MAG_W = scc_pkg::OFFSET_W;
  localparam int NUM_W = MAG_W + 2 * FRAC_BITS;
  localparam int DVD_W = (NUM_W > DW) ? NUM_W : DW;
  localparam logic signed [DW-1:0] THR = DW'((4 * (1 << FRAC_BITS)) / 5);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_NEG  = 3'd4;
  localparam logic [2:0] S_PWR  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // Divider jobs
  localparam logic [1:0] OP_CUR = 2'd0;
  localparam logic [1:0] OP_IN  = 2'd1;
  localparam logic [1:0] OP_OUT = 2'd2;
  localparam logic [1:0] OP_AVG = 2'd3;

  // Configuration registers
  logic                   single_r;
  logic [MAG_W-1:0]       offset_r;
  logic [GW-1:0]          gain_r;

  // Control
  logic [2:0]             state_r;
  logic [1:0]             op_r;
  logic                   div_go_r;
  logic                   mul_go_r;
  logic                   out_valid_r;

  // Sample and window datapath
  logic                   neg_r;
  logic [MAG_W-1:0]       mag_r;
  logic signed [DW-1:0]   volt_r;
  logic signed [DW-1:0]   cur_r;
  logic [CW-1:0]          cnt_r;
  logic [DW-1:0]          in_sum_r;
  logic [DW-1:0]          out_sum_r;
  logic [DW-1:0]          cur_sum_r;
  logic [DW-1:0]          chg_in_r;
  logic [DW-1:0]          chg_out_r;
  logic [DW-1:0]          idle_r;
  logic signed [DW-1:0]   avg_r;
  logic signed [DW-1:0]   pwr_r;
  logic [2*DW-1:0]        prod_r;
  logic                   win_r;
  scc_pkg::scc_out_t      out_data_r;

  logic                   cfg_wr;
  logic                   in_acc;
  logic signed [MAG_W:0]  raw;
  logic signed [MAG_W:0]  diff;
  logic [MAG_W:0]         diff_mag;
  logic [GW-1:0]          gain_eff;
  logic [DW-1:0]          sum_mag;
  logic [DVD_W-1:0]       div_dvd;
  logic [GW-1:0]          div_dsr;
  logic                   div_done;
  logic [DVD_W-1:0]       div_quo;
  logic                   mul_done;
  logic [2*DW-1:0]        mul_prod;
  logic                   pos_ovf;
  logic                   neg_ovf;
  logic signed [DW-1:0]   cur_nxt;
  logic signed [DW-1:0]   avg_nxt;
  logic [CW-1:0]          cnt_nxt;
  logic                   close;
  logic signed [2*DW-1:0] shifted;
  logic [DW:0]            shift_hi;
  logic signed [DW-1:0]   pwr_nxt;
  logic                   out_load;

  // Configuration port: writes complete in the access cycle, reads are immediate
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      single_r <= 1'b0;
      offset_r <= '0;
      gain_r   <= scc_pkg::GAIN_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        scc_pkg::REG_SINGLE: single_r <= pwdata[0];
        scc_pkg::REG_OFFSET: offset_r <= pwdata[MAG_W-1:0];
        scc_pkg::REG_GAIN:   gain_r   <= pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      scc_pkg::REG_SINGLE: prdata = DW'(single_r);
      scc_pkg::REG_OFFSET: prdata = {{(DW-MAG_W){offset_r[MAG_W-1]}}, offset_r};
      scc_pkg::REG_GAIN:   prdata = DW'(gain_r);
      default:             prdata = '0;
    endcase
  end

  // Raw reading minus offset, split into sign and magnitude
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign raw      = single_r
                  ? $signed({2'b00, in_data.pos_sample})
                  : $signed({2'b00, in_data.pos_sample}) - $signed({2'b00, in_data.neg_sample});
  assign diff     = raw - $signed({offset_r[MAG_W-1], offset_r});
  assign diff_mag = diff[MAG_W] ? -diff : diff;

  // Divider operand select
  assign gain_eff = (gain_r == '0) ? GW'(1) : gain_r;
  assign sum_mag  = cur_sum_r[DW-1] ? -cur_sum_r : cur_sum_r;

  always_comb begin
    case (op_r)
      OP_CUR: begin
        div_dvd = DVD_W'(mag_r) << (2 * FRAC_BITS);
        div_dsr = gain_eff;
      end
      OP_IN: begin
        div_dvd = DVD_W'(in_sum_r);
        div_dsr = GW'(WINDOW_SAMPLES);
      end
      OP_OUT: begin
        div_dvd = DVD_W'(out_sum_r);
        div_dsr = GW'(WINDOW_SAMPLES);
      end
      default: begin
        div_dvd = DVD_W'(sum_mag);
        div_dsr = GW'(WINDOW_SAMPLES);
      end
    endcase
  end

  scc_div #(
    .DVD_W (DVD_W),
    .DSR_W (GW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_quo)
  );

  scc_mul #(
    .W (DW)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_go_r),
    .a       (volt_r[DW-1] ? -volt_r : volt_r),
    .b       (avg_r[DW-1] ? -avg_r : avg_r),
    .done    (mul_done),
    .product (mul_prod)
  );

  // Saturate the signed current quotient to 32 bits
  assign pos_ovf = (div_quo >> (DW - 1)) != '0;
  assign neg_ovf = ((div_quo >> DW) != '0) || (div_quo[DW-1] && (div_quo[DW-2:0] != '0));

  always_comb begin
    if (neg_r) begin
      cur_nxt = neg_ovf ? {1'b1, {(DW-1){1'b0}}} : -$signed(div_quo[DW-1:0]);
    end else begin
      cur_nxt = pos_ovf ? {1'b0, {(DW-1){1'b1}}} : $signed(div_quo[DW-1:0]);
    end
  end

  assign avg_nxt = cur_sum_r[DW-1] ? -$signed(div_quo[DW-1:0]) : $signed(div_quo[DW-1:0]);

  // Window bookkeeping
  assign cnt_nxt = cnt_r + 1'b1;
  assign close   = cnt_nxt >= CW'(WINDOW_SAMPLES);

  // Floor shift of the power product, then saturate
  assign shifted  = $signed(prod_r) >>> FRAC_BITS;
  assign shift_hi = shifted[2*DW-1:DW-1];

  always_comb begin
    if ((shift_hi == '0) || (shift_hi == '1)) begin
      pwr_nxt = shifted[DW-1:0];
    end else begin
      pwr_nxt = shifted[2*DW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // Sequencer and state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      op_r      <= OP_CUR;
      div_go_r  <= 1'b0;
      mul_go_r  <= 1'b0;
      cnt_r     <= '0;
      in_sum_r  <= '0;
      out_sum_r <= '0;
      cur_sum_r <= '0;
      chg_in_r  <= '0;
      chg_out_r <= '0;
      idle_r    <= '0;
      avg_r     <= '0;
      pwr_r     <= '0;
      win_r     <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      mul_go_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          // Drop held samples, otherwise start the current divide
          if (in_acc && !in_data.hold) begin
            neg_r    <= diff[MAG_W];
            mag_r    <= diff_mag[MAG_W-1:0];
            volt_r   <= in_data.bus_voltage;
            op_r     <= OP_CUR;
            div_go_r <= 1'b1;
            state_r  <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            case (op_r)
              OP_CUR: begin
                cur_r   <= cur_nxt;
                state_r <= S_ACC;
              end
              OP_IN: begin
                chg_in_r <= chg_in_r + div_quo[DW-1:0];
                op_r     <= OP_OUT;
                div_go_r <= 1'b1;
              end
              OP_OUT: begin
                chg_out_r <= chg_out_r + div_quo[DW-1:0];
                op_r      <= OP_AVG;
                div_go_r  <= 1'b1;
              end
              default: begin
                avg_r    <= avg_nxt;
                mul_go_r <= 1'b1;
                state_r  <= S_MUL;
              end
            endcase
          end
        end
        S_ACC: begin
          // Sort the current into charge or discharge (clearing the idle count), else advance the idle count
          if (cur_r < -THR) begin
            out_sum_r <= out_sum_r - cur_r;
            idle_r    <= '0;
          end else if (cur_r > THR) begin
            in_sum_r <= in_sum_r + cur_r;
            idle_r   <= '0;
          end else if (idle_r != '1) begin
            idle_r <= idle_r + 1'b1;
          end
          cur_sum_r <= cur_sum_r + cur_r;
          win_r     <= close;
          if (close) begin
            cnt_r    <= '0;
            op_r     <= OP_IN;
            div_go_r <= 1'b1;
            state_r  <= S_DIV;
          end else begin
            cnt_r   <= cnt_nxt;
            state_r <= S_OUT;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            prod_r  <= mul_prod;
            state_r <= S_NEG;
          end
        end
        S_NEG: begin
          // Apply the product sign
          if (volt_r[DW-1] ^ avg_r[DW-1]) begin
            prod_r <= -prod_r;
          end
          state_r <= S_PWR;
        end
        S_PWR: begin
          pwr_r     <= pwr_nxt;
          in_sum_r  <= '0;
          out_sum_r <= '0;
          cur_sum_r <= '0;
          state_r   <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.measured_current <= cur_r;
      out_data_r.idle_count       <= idle_r;
      out_data_r.window_done      <= win_r;
      out_data_r.average_current  <= avg_r;
      out_data_r.window_power     <= pwr_r;
      out_data_r.charge_in        <= chg_in_r;
      out_data_r.charge_out       <= chg_out_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sample count never reaches the window length
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CW'(WINDOW_SAMPLES))
    else $error("sample count reached window length");

  // Divider and multiplier finish only while the sequencer waits for them
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside divide state");

  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == S_MUL)
    else $error("multiplier finished outside multiply state");

  // A sample that is not held starts a divide on the next cycle
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_data.hold) |=> (div_go_r && state_r == S_DIV && op_r == OP_CUR))
    else $error("accepted sample did not start the current divide");

  // A closed window leaves the sum registers cleared when its result is loaded
  a_win_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && win_r) |-> (cur_sum_r == '0 && in_sum_r == '0 && out_sum_r == '0))
    else $error("window closed without clearing sums");

endmodule

FILE: test/scc_checker.sv
// Shunt coulomb counter checker: sees all ports but prdata, predicts and compares results.
module scc_checker #(
  parameter int FRAC_BITS      = scc_pkg::FRAC_BITS_DEF,
  parameter int WINDOW_SAMPLES = scc_pkg::WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  scc_pkg::scc_in_t           in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  scc_pkg::scc_out_t          out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [scc_pkg::ADDR_W-1:0] paddr,
  input  logic [scc_pkg::DATA_W-1:0] pwdata,
  input  logic                       pready,
  output int                         fail_count,
  output int                         pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     DATA_W   = scc_pkg::DATA_W;
  localparam int     OFFSET_W = scc_pkg::OFFSET_W;
  localparam int     GAIN_W   = scc_pkg::GAIN_W;
  localparam int     CNT_W    = scc_pkg::CNT_W;
  localparam int     ADDR_W   = scc_pkg::ADDR_W;
  localparam longint I32_MAX  = 64'sd2147483647;
  localparam longint I32_MIN  = -64'sd2147483648;

  // Register copies
  logic                       single_mode;
  logic signed [OFFSET_W-1:0] zero_count;
  logic [GAIN_W-1:0]          gain_div;

  // Window sums, totals and latched window values
  logic [CNT_W-1:0]  n_samples;
  logic [DATA_W-1:0] drawn_in;
  logic [DATA_W-1:0] drawn_out;
  logic [DATA_W-1:0] net_acc;
  logic [DATA_W-1:0] total_in;
  logic [DATA_W-1:0] total_out;
  logic [DATA_W-1:0] idle_run;
  logic [DATA_W-1:0] avg_hold;
  logic [DATA_W-1:0] power_hold;

  scc_pkg::scc_out_t readings_due[$];
  int                n_bad;
  int                due_count;

  assign fail_count    = n_bad;
  assign pending_count = due_count;

  task automatic report_error(input string msg);
    $display("%0t ERROR: %s", $time, msg);
    n_bad++;
  endtask

  task automatic compare_field(input string name, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
    if (got !== want)
      report_error($sformatf("%s got 0x%08h, expected 0x%08h", name, got, want));
  endtask

  function automatic logic signed [DATA_W-1:0] clamp_i32(input longint v);
    if (v > I32_MAX) return DATA_W'(I32_MAX);
    if (v < I32_MIN) return DATA_W'(I32_MIN);
    return DATA_W'(v);
  endfunction

  // Update sums and totals for one sample and return the reading it produces
  function automatic scc_pkg::scc_out_t account_sample(input scc_pkg::scc_in_t s);
    scc_pkg::scc_out_t        r;
    longint                   raw;
    longint                   num;
    longint                   div;
    longint                   cur_l;
    longint                   avg;
    longint                   prod;
    longint                   thr;
    logic signed [DATA_W-1:0] cur;
    thr = (4 * (longint'(1) << FRAC_BITS)) / 5;
    raw = single_mode ? longint'(s.pos_sample)
                      : longint'(s.pos_sample) - longint'(s.neg_sample);
    num = (raw - longint'(zero_count)) * (longint'(1) << (2 * FRAC_BITS));
    div = (gain_div == '0) ? 64'sd1 : longint'(gain_div);
    cur = clamp_i32(num / div);
    cur_l = longint'(cur);

    // Charge or discharge above the threshold, idle otherwise
    if (cur_l < -thr) begin
      drawn_out = drawn_out + DATA_W'(-cur_l);
      idle_run = '0;
    end else if (cur_l > thr) begin
      drawn_in = drawn_in + DATA_W'(cur_l);
      idle_run = '0;
    end else if (idle_run != '1) begin
      idle_run = idle_run + 1'b1;
    end
    net_acc = net_acc + DATA_W'(cur_l);
    n_samples = n_samples + 1'b1;

    // Close the window: fold sums into totals, latch average and power
    r.window_done = 1'b0;
    if (n_samples >= WINDOW_SAMPLES) begin
      total_in = total_in + drawn_in / DATA_W'(WINDOW_SAMPLES);
      total_out = total_out + drawn_out / DATA_W'(WINDOW_SAMPLES);
      avg = longint'($signed(net_acc)) / WINDOW_SAMPLES;
      prod = longint'($signed(s.bus_voltage)) * avg;
      power_hold = clamp_i32(prod >>> FRAC_BITS);
      avg_hold = DATA_W'(avg);
      drawn_in = '0;
      drawn_out = '0;
      net_acc = '0;
      n_samples = '0;
      r.window_done = 1'b1;
    end

    r.measured_current = cur;
    r.idle_count = idle_run;
    r.average_current = avg_hold;
    r.window_power = power_hold;
    r.charge_in = total_in;
    r.charge_out = total_out;
    return r;
  endfunction

  always @(posedge clk) begin : track
    scc_pkg::scc_out_t want;
    if (!rst_n) begin
      single_mode = 1'b0;
      zero_count = '0;
      gain_div = scc_pkg::GAIN_RESET;
      n_samples = '0;
      drawn_in = '0;
      drawn_out = '0;
      net_acc = '0;
      total_in = '0;
      total_out = '0;
      idle_run = '0;
      avg_hold = '0;
      power_hold = '0;
      readings_due.delete();
      due_count <= 0;
    end else begin
      // Match the result request against the oldest expected reading
      if (out_valid && out_ready) begin
        if (readings_due.size() == 0) begin
          report_error($sformatf("result with no sample pending, current %0d",
                                 out_data.measured_current));
        end else begin
          want = readings_due.pop_front();
          compare_field("measured_current", out_data.measured_current,
                        want.measured_current);
          compare_field("idle_count", out_data.idle_count, want.idle_count);
          compare_field("window_done", DATA_W'(out_data.window_done),
                        DATA_W'(want.window_done));
          compare_field("average_current", out_data.average_current,
                        want.average_current);
          compare_field("window_power", out_data.window_power, want.window_power);
          compare_field("charge_in", out_data.charge_in, want.charge_in);
          compare_field("charge_out", out_data.charge_out, want.charge_out);
        end
      end

      // Held samples drop out without a reading
      if (in_valid && in_ready && !in_data.hold)
        readings_due.push_back(account_sample(in_data));

      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          scc_pkg::REG_SINGLE: single_mode = pwdata[0];
          scc_pkg::REG_OFFSET: zero_count = pwdata[OFFSET_W-1:0];
          scc_pkg::REG_GAIN:   gain_div = pwdata[GAIN_W-1:0];
          default: ;
        endcase
      end
      due_count <= readings_due.size();
    end
  end

endmodule

FILE: test/testbench.sv
// Top of the shunt coulomb counter test: clock, reset, stimulus, stalls and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDR_W         = scc_pkg::ADDR_W;
  localparam int DATA_W         = scc_pkg::DATA_W;
  localparam int SAMPLE_W       = scc_pkg::SAMPLE_W;
  localparam int PHASE_ITEMS    = 308;
  localparam int HOLD_PCT       = 3;
  localparam int DRAIN_CYCLES   = 200;
  localparam int LONG_STALL     = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  scc_pkg::scc_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  scc_pkg::scc_out_t out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending_count;
  int tx_idle_pct;
  int rx_idle_pct;
  bit long_stall_req;
  int quiet_cycles;
  int n_sent;
  int n_held;
  int n_settings;
  bit cfg_single;
  int cfg_offset;

  shunt_coulomb_counter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  scc_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int stall_left;
    bit stall_taken;
    stall_left = 0;
    stall_taken = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_req && !stall_taken) begin
        stall_taken = 1'b1;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Abort when no request or register write moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("shunt_coulomb_counter: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic scc_pkg::scc_in_t sample_of(input int pos, input int neg, input int volt,
                                                 input bit hold);
    scc_pkg::scc_in_t s;
    s.pos_sample = SAMPLE_W'(pos);
    s.neg_sample = SAMPLE_W'(neg);
    s.bus_voltage = DATA_W'(volt);
    s.hold = hold;
    return s;
  endfunction

  // Random sample: near the zero point, on the high side, or anywhere
  function automatic scc_pkg::scc_in_t make_sample(input int near_pct, input bit high_side);
    scc_pkg::scc_in_t s;
    int               d;
    int               base;
    s.hold = ($urandom_range(99) < HOLD_PCT);
    case ($urandom_range(9))
      0:       s.bus_voltage = 32'sh8000_0000;
      1:       s.bus_voltage = 32'sh7FFF_FFFF;
      2:       s.bus_voltage = '0;
      3:       s.bus_voltage = '1;
      default: s.bus_voltage = $urandom;
    endcase
    s.neg_sample = SAMPLE_W'($urandom_range(4095));
    if (high_side) begin
      s.pos_sample = SAMPLE_W'($urandom_range(4095, 2048));
    end else if ($urandom_range(99) < near_pct) begin
      d = int'($urandom_range(80)) - 40;
      base = cfg_offset + d + (cfg_single ? 0 : int'(s.neg_sample));
      if (base < 0) base = 0;
      else if (base > 4095) base = 4095;
      s.pos_sample = SAMPLE_W'(base);
    end else begin
      s.pos_sample = SAMPLE_W'($urandom_range(4095));
    end
    return s;
  endfunction

  // Offer one sample request, idling at random first; returns at a falling edge
  task automatic send_sample(input scc_pkg::scc_in_t s);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    if (s.hold) n_held++;
    @(negedge clk);
  endtask

  // Stop sending and let every pending result drain
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  task automatic load_settings(input bit single, input int offset, input int gain);
    settle();
    write_reg(scc_pkg::REG_SINGLE, DATA_W'(single));
    write_reg(scc_pkg::REG_OFFSET, DATA_W'(offset) & 32'h0000_1FFF);
    write_reg(scc_pkg::REG_GAIN, DATA_W'(gain) & 32'h7FFF_FFFF);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_single = single;
    cfg_offset = offset;
    n_settings++;
  endtask

  initial begin : stimulus
    bit p_single;
    int p_offset;
    int p_gain;
    int p_near;
    bit p_high;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    long_stall_req = 1'b0;
    tx_idle_pct = 31;
    rx_idle_pct = 51;
    n_sent = 0;
    n_held = 0;
    n_settings = 0;
    cfg_single = 1'b0;
    cfg_offset = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: zero reading, full-scale both ways, held samples
    send_sample(sample_of(0, 0, 0, 1'b0));
    send_sample(sample_of(4095, 0, 32'h7FFF_FFFF, 1'b0));
    send_sample(sample_of(0, 4095, 32'h8000_0000, 1'b0));
    send_sample(sample_of(4095, 4095, -1, 1'b1));
    send_sample(sample_of(123, 45, 0, 1'b1));

    // Unity scale: current equals raw count, probe both sides of the threshold
    load_settings(1'b0, 0, 1024);
    send_sample(sample_of(25, 0, 1000, 1'b0));
    send_sample(sample_of(26, 0, 1000, 1'b0));
    send_sample(sample_of(0, 25, -1000, 1'b0));
    send_sample(sample_of(0, 26, -1000, 1'b0));

    // Single ended, lowest offset, smallest gain: largest positive current
    load_settings(1'b1, -4096, 1);
    send_sample(sample_of(4095, 0, 32'h7FFF_FFFF, 1'b0));
    send_sample(sample_of(0, 4095, 32'h8000_0000, 1'b0));

    // Highest offset, zero gain acts as one: largest negative current
    load_settings(1'b0, 4095, 0);
    send_sample(sample_of(0, 4095, 32'h8000_0000, 1'b0));
    send_sample(sample_of(4095, 0, 32'h7FFF_FFFF, 1'b0));

    // Largest gain: small currents round toward zero
    load_settings(1'b0, 0, 32'h7FFF_FFFF);
    send_sample(sample_of(0, 4095, 0, 1'b0));
    send_sample(sample_of(4095, 0, 0, 1'b0));

    // Random phases; the high-side phases overflow the sums before the window closes
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          p_single = 1'b0; p_offset = int'($urandom_range(600)) - 300;
          p_gain = $urandom_range(1400, 700); p_near = 60; p_high = 1'b0;
        end
        1: begin
          p_single = 1'b1; p_offset = -4096; p_gain = 1; p_near = 0; p_high = 1'b1;
        end
        2: begin
          p_single = 1'b1; p_offset = -4000; p_gain = 0; p_near = 0; p_high = 1'b1;
        end
        3: begin
          p_single = 1'b0; p_offset = 4095; p_gain = 1; p_near = 0; p_high = 1'b0;
        end
        4: begin
          p_single = 1'b1; p_offset = int'($urandom_range(8191)) - 4096;
          p_gain = $urandom_range(4096, 1); p_near = 50; p_high = 1'b0;
        end
        default: begin
          p_single = 1'b0; p_offset = int'($urandom_range(8191)) - 4096;
          p_gain = 32'h7FFF_FFFF; p_near = 30; p_high = 1'b0;
        end
      endcase
      load_settings(p_single, p_offset, p_gain);
      if (p < 2) begin
        tx_idle_pct = 31;
        rx_idle_pct = 51;
      end else if (p < 4) begin
        tx_idle_pct = 51;
        rx_idle_pct = 31;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // Hold results off for a long stretch while samples keep being offered
      if (p == 2) long_stall_req = 1'b1;
      repeat (PHASE_ITEMS) send_sample(make_sample(p_near, p_high));
    end

    settle();
    $display("Covered %0d samples (%0d held) over %0d register settings,",
             n_sent, n_held, n_settings);
    $display("with idling on both sides, a long result stall and a wrapped window.");
    if (fail_count == 0) begin
      $display("shunt_coulomb_counter: match");
    end else begin
      $display("shunt_coulomb_counter: mismatch");
    end
    $finish;
  end

endmodule
